// File: src/spq_pkg.sv
// Package for the sorted priority queue: sizes, codes and the types shared by the cells.
package spq_pkg;

   localparam int unsigned DEPTH  = 16;
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned OCC_W  = 5;
   localparam int unsigned WORD_W = 32;

   typedef enum logic [1:0] {
      FUNC_PUSH = 2'd0,
      FUNC_POP  = 2'd1,
      FUNC_DEL  = 2'd2,
      FUNC_NOP  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_FULL     = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_NOTFOUND = 2'd3
   } status_type;

   // Per-cycle action broadcast along the row of cells
   typedef enum logic [1:0] {
      OP_HOLD = 2'd0,
      OP_PUSH = 2'd1,
      OP_POP  = 2'd2,
      OP_DEL  = 2'd3
   } op_type;

   typedef struct packed {
      logic                     used;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      op_type                   op;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] prio;
   } cmd_type;

endpackage

// File: src/spq_cell.sv
// One slot of the sorted queue: holds an entry and trades it with its neighbours.
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  logic      left_ins,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output entry_type cur_entry,
   output entry_type next_entry,
   output logic      ins,
   output logic      match
);

   entry_type entry_ff;
   entry_type entry_in;

   // Slots are sorted, so ins is low for a prefix of the row and high after it
   assign ins   = !entry_ff.used || ($signed(entry_ff.prio) >= $signed(cmd.prio));
   assign match = entry_ff.used && (entry_ff.prio == cmd.prio);

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_PUSH: begin
            if (left_ins) begin
               entry_in = left_entry;
            end else if (ins) begin
               entry_in.used  = 1'b1;
               entry_in.value = cmd.value;
               entry_in.prio  = cmd.prio;
            end
         end
         OP_POP: begin
            entry_in = right_entry;
         end
         OP_DEL: begin
            // first match sits where ins turns high; close the gap from there on
            if (ins) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff.value <= entry_in.value;
      entry_ff.prio  <= entry_in.prio;
      if (reset) begin
         entry_ff.used <= 1'b0;
      end else begin
         entry_ff.used <= entry_in.used;
      end
   end

   assign cur_entry  = entry_ff;
   assign next_entry = entry_in;

endmodule

// File: src/sorted_insertion_priority_queue.sv
// The result beat for an item is registered and presented in the cycle after the item is accepted.
// One item per cycle while req_tready is high; every cell compares and shifts in the same cycle.
// req_tready stays high while the result register is empty or being taken.
// Reset (synchronous, active high) clears the used bits, the count and the result valid.
// Entry data is not cleared; an unused slot is never shown, so no clearing pass is run.
module sorted_insertion_priority_queue
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // value[31:0], prio[63:32]
   input  logic [1:0]  req_tuser,  // func[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,  // head_value[31:0], head_prio[63:32], occupancy[68:64], zero
   output logic [2:0]  rsp_tuser   // status[1:0], head_valid[2]
);

   entry_type  cur_entry  [DEPTH];
   entry_type  next_entry [DEPTH];
   logic [DEPTH-1:0] ins_vec;
   logic [DEPTH-1:0] match_vec;
   logic [DEPTH-1:0] used_vec;

   cmd_type    cmd;
   status_type status;
   func_type   func;
   logic       accept;
   logic       found;
   logic       full;
   logic       empty;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               rsp_status_ff;
   logic                     rsp_head_valid_ff;
   logic signed [WORD_W-1:0] rsp_head_value_ff;
   logic signed [WORD_W-1:0] rsp_head_prio_ff;
   logic [OCC_W-1:0]         rsp_occ_ff;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign func       = func_type'(req_tuser);
   assign found      = |match_vec;
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic      left_ins;
         entry_type left_entry;
         entry_type right_entry;

         if (gi == 0) begin : g_first
            assign left_ins   = 1'b0;
            assign left_entry = '0;
         end else begin : g_mid
            assign left_ins   = ins_vec[gi-1];
            assign left_entry = cur_entry[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_last
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = cur_entry[gi+1];
         end

         spq_cell u_cell (
            .clock       (clock),
            .reset       (reset),
            .cmd         (cmd),
            .left_ins    (left_ins),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .cur_entry   (cur_entry[gi]),
            .next_entry  (next_entry[gi]),
            .ins         (ins_vec[gi]),
            .match       (match_vec[gi])
         );

         assign used_vec[gi] = cur_entry[gi].used;
      end
   endgenerate

   // Decode the beat into the row command, the status and the new count
   always_comb begin
      cmd.op    = OP_HOLD;
      cmd.value = $signed(req_tdata[31:0]);
      cmd.prio  = $signed(req_tdata[63:32]);
      status    = ST_OK;
      count_in  = count_ff;
      if (accept) begin
         case (func)
            FUNC_PUSH: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  cmd.op   = OP_PUSH;
                  count_in = count_ff + 1'b1;
               end
            end
            FUNC_POP: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  cmd.op   = OP_POP;
                  count_in = count_ff - 1'b1;
               end
            end
            FUNC_DEL: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else if (!found) begin
                  status = ST_NOTFOUND;
               end else begin
                  cmd.op   = OP_DEL;
                  count_in = count_ff - 1'b1;
               end
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the head as it will stand after this beat; zero when the queue drains
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff     <= status;
         rsp_head_valid_ff <= next_entry[0].used;
         rsp_head_value_ff <= next_entry[0].used ? next_entry[0].value : '0;
         rsp_head_prio_ff  <= next_entry[0].used ? next_entry[0].prio : '0;
         rsp_occ_ff        <= OCC_W'(count_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_occ_ff, rsp_head_prio_ff, rsp_head_value_ff};
   assign rsp_tuser  = {rsp_head_valid_ff, rsp_status_ff};

`ifndef SYNTHESIS
   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_vec) == 32'(count_ff))
      else $error("count disagrees with used slots");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count beyond depth");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      used_vec[1] |-> ($signed(cur_entry[0].prio) <= $signed(cur_entry[1].prio)))
      else $error("head out of order");

   a_full_reject: assert property (@(posedge clock) disable iff (reset)
      (accept && func == FUNC_PUSH && full) |=> (rsp_status_ff == ST_FULL && full))
      else $error("push on full queue not rejected");

   a_found_removes: assert property (@(posedge clock) disable iff (reset)
      (accept && func == FUNC_DEL && found) |=> (count_ff == $past(count_ff) - 1'b1))
      else $error("delete by priority did not remove an entry");
`endif

endmodule

// File: test/spq_checker.sv
// Checker for the sorted priority queue: tracks held entries, predicts and compares results.
`timescale 1ns / 100ps
module spq_checker
   import spq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,  // value[31:0], prio[63:32]
   input  logic [1:0]  req_tuser,  // func[1:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,  // head_value[31:0], head_prio[63:32], occupancy[68:64], zero
   input  logic [2:0]  rsp_tuser,  // status[1:0], head_valid[2]
   output int unsigned fail_count,
   output int unsigned outstanding
);

   typedef struct packed {
      status_type               status;
      logic                     head_valid;
      logic signed [WORD_W-1:0] head_value;
      logic signed [WORD_W-1:0] head_prio;
      logic [OCC_W-1:0]         occupancy;
   } queue_view_type;

   logic signed [WORD_W-1:0] slot_value [DEPTH];
   logic signed [WORD_W-1:0] slot_prio  [DEPTH];
   int unsigned              held_count;
   queue_view_type           expected_views [$];

   // Close the gap left by slot k
   function automatic void drop_slot(int unsigned k);
      for (int i = k; i + 1 < held_count; i++) begin
         slot_value[i] = slot_value[i + 1];
         slot_prio[i]  = slot_prio[i + 1];
      end
      held_count--;
   endfunction

   function automatic queue_view_type apply_queue_op(func_type f, logic signed [WORD_W-1:0] v,
                                                     logic signed [WORD_W-1:0] p);
      queue_view_type view;
      int unsigned    at;
      view        = '0;
      view.status = ST_OK;
      case (f)
         FUNC_PUSH: begin
            if (held_count >= DEPTH) begin
               view.status = ST_FULL;
            end else begin
               // insert ahead of the first entry of equal or greater priority
               at = held_count;
               for (int i = 0; i < held_count; i++) begin
                  if (slot_prio[i] >= p) begin
                     at = i;
                     break;
                  end
               end
               for (int i = held_count; i > at; i--) begin
                  slot_value[i] = slot_value[i - 1];
                  slot_prio[i]  = slot_prio[i - 1];
               end
               slot_value[at] = v;
               slot_prio[at]  = p;
               held_count++;
            end
         end
         FUNC_POP: begin
            if (held_count == 0) view.status = ST_EMPTY;
            else drop_slot(0);
         end
         FUNC_DEL: begin
            if (held_count == 0) begin
               view.status = ST_EMPTY;
            end else begin
               view.status = ST_NOTFOUND;
               for (int i = 0; i < held_count; i++) begin
                  if (slot_prio[i] == p) begin
                     drop_slot(i);
                     view.status = ST_OK;
                     break;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      view.occupancy = held_count[OCC_W-1:0];
      if (held_count > 0) begin
         view.head_valid = 1'b1;
         view.head_value = slot_value[0];
         view.head_prio  = slot_prio[0];
      end
      return view;
   endfunction

   always @(posedge clock) begin
      queue_view_type want;
      queue_view_type got;
      if (reset) begin
         held_count = 0;
         expected_views.delete();
      end else begin
         if (req_tvalid && req_tready)
            expected_views.push_back(apply_queue_op(func_type'(req_tuser), req_tdata[31:0],
                                                    req_tdata[63:32]));
         if (rsp_tvalid && rsp_tready) begin
            got.status     = status_type'(rsp_tuser[1:0]);
            got.head_valid = rsp_tuser[2];
            got.head_value = rsp_tdata[31:0];
            got.head_prio  = rsp_tdata[63:32];
            got.occupancy  = rsp_tdata[68:64];
            if (expected_views.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result beat with nothing expected: status %0d occupancy %0d",
                           $time, got.status, got.occupancy);
            end else begin
               want = expected_views.pop_front();
               if (got.status !== want.status || got.head_valid !== want.head_valid ||
                   got.head_value !== want.head_value || got.head_prio !== want.head_prio ||
                   got.occupancy !== want.occupancy) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: mismatch status %0d/%0d head_valid %0d/%0d ",
                              $time, want.status, got.status, want.head_valid,
                              got.head_valid,
                              "head_value %0d/%0d head_prio %0d/%0d occupancy %0d/%0d ",
                              want.head_value, got.head_value,
                              want.head_prio, got.head_prio, want.occupancy,
                              got.occupancy, "(expected/actual)");
               end
            end
         end
      end
      outstanding <= expected_views.size();
   end

endmodule

// File: test/tb.sv
// Testbench top for the sorted priority queue: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module tb;
   import spq_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1750;
   localparam int unsigned CYCLE_LIMIT  = 400000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = FUNC_PUSH;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic [2:0]  rsp_tuser;

   int unsigned fail_count;
   int unsigned outstanding;
   int unsigned cycle_count  = 0;
   logic        quiet_stretch = 1'b0;

   always #5 clock = ~clock;

   sorted_insertion_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   spq_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Result side: stall at random outside the quiet stretch
   always @(posedge clock) begin
      rsp_tready <= quiet_stretch || ($urandom_range(0, 99) >= 23);
   end

   task automatic send_beat(input func_type f, input logic [31:0] v, input logic [31:0] p);
      while (!quiet_stretch && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {p, v};
      req_tuser  <= f;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Hold off until every expected result beat has been taken
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Mostly a narrow band so that equal priorities and deletion hits are common
   function automatic logic [31:0] draw_priority();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 32'(int'($urandom_range(0, 7)) - 4);
      if (r < 80) return (r % 2) ? 32'h7fff_ffff : 32'h8000_0000;
      return $urandom;
   endfunction

   initial begin
      int unsigned push_weight;
      func_type    f;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, ordering at the edges, deletions, full queue
      send_beat(FUNC_POP, 32'h1234_5678, 32'd0);
      send_beat(FUNC_DEL, 32'd0, 32'd5);
      send_beat(FUNC_NOP, 32'hffff_ffff, 32'hffff_ffff);
      send_beat(FUNC_PUSH, 32'h7fff_ffff, 32'd0);
      send_beat(FUNC_PUSH, 32'h8000_0000, 32'd0);
      send_beat(FUNC_PUSH, 32'hffff_ffff, 32'h8000_0000);
      send_beat(FUNC_PUSH, 32'h0000_0000, 32'h7fff_ffff);
      send_beat(FUNC_DEL, 32'd0, 32'd1);
      send_beat(FUNC_DEL, 32'd0, 32'd0);
      send_beat(FUNC_DEL, 32'd0, 32'h8000_0000);
      send_beat(FUNC_NOP, 32'd0, 32'd0);
      for (int i = 0; i < 14; i++)
         send_beat(FUNC_PUSH, $urandom, 32'(i % 3 - 1));
      send_beat(FUNC_PUSH, 32'haaaa_5555, 32'd5);
      send_beat(FUNC_POP, 32'd0, 32'd0);
      send_beat(FUNC_DEL, 32'd0, 32'h7fff_ffff);

      // random: push share varies by block so the queue swings between empty and full
      push_weight = 50;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0) push_weight = $urandom_range(15, 85);
         if (n == 600) quiet_stretch <= 1'b1;
         if (n == 900) quiet_stretch <= 1'b0;
         if (n == 1200) drain_results();
         if ($urandom_range(0, 99) < 3) f = FUNC_NOP;
         else if ($urandom_range(0, 99) < push_weight) f = FUNC_PUSH;
         else if ($urandom_range(0, 99) < 60) f = FUNC_POP;
         else f = FUNC_DEL;
         send_beat(f, $urandom, draw_priority());
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
